FILE: sv/differential_drive_odometry_defines.svh
// Assertion macros for the odometry block
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH

// check that a condition implies a consequence in the same cycle
`define ODO_ASSERT_SAME(label, cond, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error("odometry check failed");

// check that a condition implies a consequence in the next cycle
`define ODO_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("odometry check failed");

`endif

FILE: sv/odo_pkg.sv
// Shared types, constants and helpers for the odometry block
package odo_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] REG_WHEEL_RADIUS = 2'd0;
  localparam logic [1:0] REG_INV_BASE     = 2'd1;

  typedef struct packed {
    logic speed_en;
    logic dist_en;
    logic sum_en;
  } lane_ctrl_t;

  // clamp a wide signed value to the signed 32-bit distance range
  function automatic logic signed [31:0] sat_dist(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < 40'shFF80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // arctangent of 2^-i in 2^-32 turns
  function automatic logic [31:0] cordic_atan(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/differential_drive_odometry.sv
// Top level: wheel lanes, heading and position merge, sequencer, ports
//
//  channel   | dir | handshake                   | payload
//  s_axis    | in  | s_axis_tvalid_i/tready_o    | time, left and right angular velocity
//  m_axis    | out | m_axis_tvalid_o/tready_i    | pose, heading, distances, speeds
//  cfg       | in  | cfg_we_i (no wait)          | wheel radius, inverse wheel base
//
// A request runs through the speed, distance, sum, heading and start states, the
// 24-step CORDIC with its map and done registers, the two multiply states and
// the position and output states. A stalled result holds the output state.
// One request is in flight at a time; the next is taken once the previous
// result sits in the output register, even if that result is not yet taken.
// Reset puts heading at a quarter turn and all sums and positions at zero.
module differential_drive_odometry (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // time_ms[31:0], left_angular_velocity[47:32], right_angular_velocity[63:48]
  input  logic [63:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // pose_x[31:0], pose_y[63:32], heading[79:64], travelled[111:80],
  // left_travelled[143:112], right_travelled[175:144], left_speed[191:176],
  // right_speed[207:192]
  output logic [207:0] m_axis_tdata_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);
  import odo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SPEED, S_DIST, S_SUM, S_TURN, S_ROT_GO, S_ROT,
    S_MUL_LO, S_MUL_HI, S_POS, S_OUT
  } state_e;

  state_e state_q;

  logic [15:0] radius_q, inv_base_q;
  logic [31:0] prev_time_q, elapsed_q;
  logic signed [15:0] omega_l_q, omega_r_q;
  logic signed [31:0] centre_q, csum_q, pos_x_q, pos_y_q;
  logic signed [32:0] diff_q;
  logic [ANGLE_BITS-1:0] angle_q;
  logic signed [49:0] lo_x_q, lo_y_q;
  logic signed [48:0] hi_x_q, hi_y_q;
  logic m_valid_q;
  logic [207:0] m_data_q;

  lane_ctrl_t lane_ctrl;
  logic signed [15:0] avg_l, avg_r;
  logic signed [31:0] dist_l, dist_r, sum_l, sum_r;
  logic cordic_start, cordic_done;
  logic signed [33:0] cos_v, sin_v;

  logic [31:0] time_in;
  logic signed [32:0] centre_wide, diff_wide;
  logic signed [49:0] turn_prod;
  logic signed [65:0] px_prod, py_prod;
  logic signed [35:0] dx_pos, dy_pos;
  logic in_fire, out_free;

  assign time_in         = s_axis_tdata_i[31:0];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  always_comb begin
    lane_ctrl.speed_en = (state_q == S_SPEED);
    lane_ctrl.dist_en  = (state_q == S_DIST);
    lane_ctrl.sum_en   = (state_q == S_SUM);
    cordic_start       = (state_q == S_ROT_GO);
    centre_wide = {dist_l[31], dist_l} + {dist_r[31], dist_r};
    diff_wide   = {dist_l[31], dist_l} - {dist_r[31], dist_r};
    turn_prod   = $signed(diff_q) * $signed({1'b0, inv_base_q});
    px_prod = $signed({hi_x_q, 17'b0}) + {{16{lo_x_q[49]}}, lo_x_q};
    py_prod = $signed({hi_y_q, 17'b0}) + {{16{lo_y_q[49]}}, lo_y_q};
    dx_pos  = px_prod[65:30];
    dy_pos  = py_prod[65:30];
  end

  odo_lane u_lane_l (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (lane_ctrl),
    .omega_i   (omega_l_q),
    .radius_i  (radius_q),
    .elapsed_i (elapsed_q),
    .avg_o     (avg_l),
    .dist_o    (dist_l),
    .sum_o     (sum_l)
  );

  odo_lane u_lane_r (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (lane_ctrl),
    .omega_i   (omega_r_q),
    .radius_i  (radius_q),
    .elapsed_i (elapsed_q),
    .avg_o     (avg_r),
    .dist_o    (dist_r),
    .sum_o     (sum_r)
  );

  odo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (angle_q),
    .done_o  (cordic_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radius_q    <= 16'd2048;
      inv_base_q  <= 16'd256;
      prev_time_q <= '0;
      csum_q      <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      angle_q     <= ANGLE_BITS'(1) << (ANGLE_BITS - 2);
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WHEEL_RADIUS) begin
          radius_q <= cfg_data_i;
        end else if (cfg_idx_i == REG_INV_BASE) begin
          inv_base_q <= cfg_data_i;
        end
      end
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            prev_time_q <= time_in;
            state_q     <= S_SPEED;
          end
        end
        S_SPEED: state_q <= S_DIST;
        S_DIST:  state_q <= S_SUM;
        S_SUM: begin
          csum_q  <= sat_dist({{8{centre_wide[32]}}, centre_wide[32:1]}
                              + {{8{csum_q[31]}}, csum_q});
          state_q <= S_TURN;
        end
        S_TURN: begin
          angle_q <= angle_q + turn_prod[24 +: ANGLE_BITS];
          state_q <= S_ROT_GO;
        end
        S_ROT_GO: state_q <= S_ROT;
        S_ROT: begin
          if (cordic_done) begin
            state_q <= S_MUL_LO;
          end
        end
        S_MUL_LO: state_q <= S_MUL_HI;
        S_MUL_HI: state_q <= S_POS;
        S_POS: begin
          pos_x_q <= sat_dist({{8{pos_x_q[31]}}, pos_x_q} + {{4{dx_pos[35]}}, dx_pos});
          pos_y_q <= sat_dist({{8{pos_y_q[31]}}, pos_y_q} + {{4{dy_pos[35]}}, dy_pos});
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      elapsed_q <= time_in - prev_time_q;
      omega_l_q <= s_axis_tdata_i[47:32];
      omega_r_q <= s_axis_tdata_i[63:48];
    end
    if (state_q == S_SUM) begin
      centre_q <= centre_wide[32:1];
      diff_q   <= diff_wide;
    end
    if (state_q == S_MUL_LO) begin
      lo_x_q <= centre_q * $signed({1'b0, cos_v[16:0]});
      lo_y_q <= centre_q * $signed({1'b0, sin_v[16:0]});
    end
    if (state_q == S_MUL_HI) begin
      hi_x_q <= centre_q * $signed(cos_v[33:17]);
      hi_y_q <= centre_q * $signed(sin_v[33:17]);
    end
    if (state_q == S_OUT && out_free) begin
      m_data_q <= {avg_r, avg_l, sum_r, sum_l, csum_q, angle_q, pos_y_q, pos_x_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`include "differential_drive_odometry_defines.svh"

  `ODO_ASSERT_NEXT(a_one_request, in_fire, !s_axis_tready_o)
  `ODO_ASSERT_SAME(a_cordic_done_wait, cordic_done, state_q == S_ROT)
  `ODO_ASSERT_SAME(a_out_heading, $rose(m_valid_q), m_axis_tdata_o[79:64] == angle_q)

endmodule

FILE: sv/odo_lane.sv
// One wheel lane: linear speed, averaged speed, distance and running sum
module odo_lane (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  odo_pkg::lane_ctrl_t      ctrl_i,
  input  logic signed [15:0]       omega_i,
  input  logic [15:0]              radius_i,
  input  logic [31:0]              elapsed_i,
  output logic signed [15:0]       avg_o,
  output logic signed [31:0]       dist_o,
  output logic signed [31:0]       sum_o
);
  import odo_pkg::*;

  localparam logic signed [48:0] DPROD_MAX = 49'sd8388607;
  localparam logic signed [48:0] DPROD_MIN = -49'sd8388608;

  logic signed [15:0] prev_q, avg_q;
  logic signed [31:0] dist_q, sum_q;
  logic signed [32:0] spd_prod;
  logic signed [15:0] spd;
  logic signed [16:0] avg_sum;
  logic signed [48:0] dist_prod;
  logic signed [31:0] dist_d, sum_d;

  always_comb begin
    spd_prod = $signed(omega_i) * $signed({1'b0, radius_i});
    spd      = spd_prod[31:16];
    avg_sum  = {spd[15], spd} + {prev_q[15], prev_q};
    dist_prod = $signed(avg_q) * $signed({1'b0, elapsed_i});
    if (dist_prod > DPROD_MAX) begin
      dist_d = 32'sh7FFFFFFF;
    end else if (dist_prod < DPROD_MIN) begin
      dist_d = 32'sh80000000;
    end else begin
      dist_d = {dist_prod[23:0], 8'h00};
    end
    sum_d = sat_dist({{8{sum_q[31]}}, sum_q} + {{8{dist_q[31]}}, dist_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      sum_q  <= '0;
    end else begin
      if (ctrl_i.speed_en) begin
        prev_q <= spd;
      end
      if (ctrl_i.sum_en) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.speed_en) begin
      avg_q <= avg_sum[16:1];
    end
    if (ctrl_i.dist_en) begin
      dist_q <= dist_d;
    end
  end

  assign avg_o  = avg_q;
  assign dist_o = dist_q;
  assign sum_o  = sum_q;

endmodule

FILE: sv/odo_cordic.sv
// Iterative rotation CORDIC: cos and sin of a binary angle, one step a cycle
module odo_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [odo_pkg::ANGLE_BITS-1:0]    angle_i,
  output logic                              done_o,
  output logic signed [33:0]                cos_o,
  output logic signed [33:0]                sin_o
);
  import odo_pkg::*;

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  logic               busy_q, map_q, done_q;
  logic [4:0]         cnt_q;
  logic [1:0]         quad_q;
  logic signed [33:0] x_q, y_q, dx, dy;
  logic signed [32:0] z_q, atan;
  logic signed [33:0] cos_q, sin_q;
  logic [31:0]        turn;

  always_comb begin
    turn = {angle_i, {(32 - ANGLE_BITS){1'b0}}};
    dx   = y_q >>> cnt_q;
    dy   = x_q >>> cnt_q;
    atan = $signed({1'b0, cordic_atan(cnt_q)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      map_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= map_q;
      map_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          map_q  <= 1'b1;
        end
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quad_q <= turn[31:30];
      z_q    <= $signed({3'b000, turn[29:0]});
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan;
      end
    end
    // map the first-quadrant result to the real quadrant
    if (map_q) begin
      case (quad_q)
        2'd0: begin cos_q <= x_q;  sin_q <= y_q;  end
        2'd1: begin cos_q <= -y_q; sin_q <= x_q;  end
        2'd2: begin cos_q <= -x_q; sin_q <= -y_q; end
        default: begin cos_q <= y_q; sin_q <= -x_q; end
      endcase
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

FILE: sim/differential_drive_odometry_tb.sv
// Testbench for the odometry block: directed and random stimulus checked against a pose predictor
`timescale 1ns / 100ps

module differential_drive_odometry_tb;
  import odo_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  // packed in the same order as m_axis_tdata
  typedef struct packed {
    logic [15:0] right_speed;
    logic [15:0] left_speed;
    logic [31:0] right_travelled;
    logic [31:0] left_travelled;
    logic [31:0] travelled;
    logic [15:0] heading;
    logic [31:0] pose_y;
    logic [31:0] pose_x;
  } pose_t;

  class pose_scoreboard;
    longint unsigned radius, inv_base;
    logic [31:0] last_time;
    longint last_ls, last_rs, sum_l, sum_r, sum_c, pos_x, pos_y;
    logic [15:0] ang;
    pose_t pending[$];
    int errors;
    longint atan_tbl[24];

    function new();
      atan_tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                   32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                   32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                   32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                   32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      radius = 2048; inv_base = 256; last_time = 0;
      last_ls = 0; last_rs = 0; sum_l = 0; sum_r = 0; sum_c = 0;
      pos_x = 0; pos_y = 0; ang = 16'd16384; errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == REG_WHEEL_RADIUS) radius = val;
      else if (idx == REG_INV_BASE) inv_base = val;
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void rotate(logic [15:0] a, output longint co, output longint si);
      logic [31:0] t;
      longint x, y, z, dx, dy;
      t = {a, 16'h0000};
      z = longint'(t[29:0]);
      x = longint'(CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tbl[i];
        end else begin
          x += dx; y -= dy; z += atan_tbl[i];
        end
      end
      case (t[31:30])
        2'd0: begin co = x; si = y; end
        2'd1: begin co = -y; si = x; end
        2'd2: begin co = -x; si = -y; end
        default: begin co = y; si = -x; end
      endcase
    endfunction

    function void note_request(logic [63:0] d);
      logic [31:0] now, el;
      logic signed [15:0] wl, wr;
      longint cl, cr, al, ar, dl, dr, ctr, turn, co, si;
      pose_t p;
      now = d[31:0];
      wl = d[47:32];
      wr = d[63:48];
      el = now - last_time;
      last_time = now;
      cl = (longint'(wl) * longint'(radius)) >>> 16;
      cr = (longint'(wr) * longint'(radius)) >>> 16;
      al = (cl + last_ls) >>> 1;
      ar = (cr + last_rs) >>> 1;
      last_ls = cl;
      last_rs = cr;
      dl = clamp(al * longint'(el) * 256);
      dr = clamp(ar * longint'(el) * 256);
      sum_l = clamp(sum_l + dl);
      sum_r = clamp(sum_r + dr);
      ctr = (dl + dr) >>> 1;
      sum_c = clamp(sum_c + ctr);
      turn = ((dl - dr) * longint'(inv_base)) >>> 24;
      ang = ang + turn[15:0];
      rotate(ang, co, si);
      pos_x = clamp(pos_x + ((ctr * co) >>> 30));
      pos_y = clamp(pos_y + ((ctr * si) >>> 30));
      p.pose_x = pos_x[31:0];
      p.pose_y = pos_y[31:0];
      p.heading = ang;
      p.travelled = sum_c[31:0];
      p.left_travelled = sum_l[31:0];
      p.right_travelled = sum_r[31:0];
      p.left_speed = al[15:0];
      p.right_speed = ar[15:0];
      pending.push_back(p);
    endfunction

    function void check_pose(pose_t got);
      pose_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.pose_x !== exp.pose_x)
        $display("%0t: pose_x exp %h got %h", $time, exp.pose_x, got.pose_x);
      if (got.pose_y !== exp.pose_y)
        $display("%0t: pose_y exp %h got %h", $time, exp.pose_y, got.pose_y);
      if (got.heading !== exp.heading)
        $display("%0t: heading exp %h got %h", $time, exp.heading, got.heading);
      if (got.travelled !== exp.travelled)
        $display("%0t: travelled exp %h got %h", $time, exp.travelled, got.travelled);
      if (got.left_travelled !== exp.left_travelled)
        $display("%0t: left_travelled exp %h got %h", $time, exp.left_travelled,
                 got.left_travelled);
      if (got.right_travelled !== exp.right_travelled)
        $display("%0t: right_travelled exp %h got %h", $time, exp.right_travelled,
                 got.right_travelled);
      if (got.left_speed !== exp.left_speed)
        $display("%0t: left_speed exp %h got %h", $time, exp.left_speed, got.left_speed);
      if (got.right_speed !== exp.right_speed)
        $display("%0t: right_speed exp %h got %h", $time, exp.right_speed, got.right_speed);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid_i, s_axis_tready_o;
  logic [63:0]  s_axis_tdata_i;
  logic         m_axis_tvalid_o, m_axis_tready_i;
  logic [207:0] m_axis_tdata_o;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [15:0]  cfg_data_i;

  pose_scoreboard sb;
  logic [31:0] clock_ms;
  int idle_cycles = 0;
  int out_stall = 0;
  bit no_idle;

  differential_drive_odometry dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side: check, then draw the next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_pose(m_axis_tdata_o);
        out_stall = no_idle ? 0 : $urandom_range(0, 13);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      m_axis_tready_i <= (out_stall == 0);
    end else begin
      m_axis_tready_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL differential_drive_odometry");
      $finish;
    end
  end

  task automatic send_request(logic [31:0] t, logic [15:0] wl, logic [15:0] wr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {wr, wl, t};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request({wr, wl, t});
  endtask

  // advance the timestamp by a small step, now and then by a wild one
  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) clock_ms = $urandom;
    else if (pick == 1) clock_ms = clock_ms - $urandom_range(1, 1000);
    else clock_ms = clock_ms + $urandom_range(0, 40);
    send_request(clock_ms, 16'($urandom), 16'($urandom));
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_WHEEL_RADIUS;
    cfg_data_i = '0;
    no_idle = 1'b0;
    clock_ms = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first item: elapsed equals the timestamp itself
    send_request(32'd10, 16'h0100, 16'h0100);
    send_request(32'd20, 16'h7FFF, 16'h8000);
    send_request(32'd21, 16'h8000, 16'h7FFF);
    send_request(32'd21, 16'h1234, 16'hFFFF);
    send_request(32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF);
    send_request(32'h0000_0003, 16'h8000, 16'h8000);
    send_request(32'h0000_0002, 16'h0000, 16'h0001);
    send_request(32'h8000_0000, 16'hFFFF, 16'h0000);
    send_request(32'h8000_0010, 16'h0400, 16'hFC00);
    settle();
    write_reg(REG_WHEEL_RADIUS, 16'hFFFF);
    write_reg(REG_INV_BASE, 16'hFFFF);
    write_reg(REG_SPARE, 16'h0000);
    write_reg(2'd2, 16'hFFFF);
    send_request(32'h8000_0020, 16'h7FFF, 16'h8000);
    send_request(32'h8000_0040, 16'h8000, 16'h7FFF);
    send_request(32'h8000_0041, 16'h0800, 16'h0700);
    send_request(32'h8000_0041, 16'h5555, 16'hAAAA);
    settle();
    // zero radius and zero gain
    write_reg(REG_WHEEL_RADIUS, 16'h0000);
    write_reg(REG_INV_BASE, 16'h0000);
    send_request(32'h8000_0100, 16'h7FFF, 16'h8000);
    send_request(32'h8000_0200, 16'h1000, 16'h2000);
    settle();
    write_reg(REG_WHEEL_RADIUS, 16'h4000);
    send_request(32'h8000_0300, 16'h7FFF, 16'h0000);
    send_request(32'h8000_0400, 16'h0000, 16'h7FFF);
    clock_ms = 32'h8000_0400;

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(REG_WHEEL_RADIUS, 16'd2048);
          write_reg(REG_INV_BASE, 16'd256);
        end
        1: begin
          write_reg(REG_WHEEL_RADIUS, 16'hFFFF);
          write_reg(REG_INV_BASE, 16'h0001);
        end
        2: begin
          write_reg(REG_WHEEL_RADIUS, 16'h0001);
          write_reg(REG_INV_BASE, 16'hFFFF);
        end
        default: begin
          write_reg(REG_WHEEL_RADIUS, 16'($urandom));
          write_reg(REG_INV_BASE, 16'($urandom));
        end
      endcase
      no_idle = (phase == 3);
      for (int n = 0; n < 50; n++) send_random();
      no_idle = 1'b0;
    end

    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS differential_drive_odometry");
    else
      $display("FAIL differential_drive_odometry");
    $finish;
  end

endmodule

FILE: differential_drive_odometry.f
+incdir+sv
sv/odo_pkg.sv
sv/odo_lane.sv
sv/odo_cordic.sv
sv/differential_drive_odometry.sv
sim/differential_drive_odometry_tb.sv
